/* src/slfd_pkg.sv */
package slfd_pkg;

    localparam int DATA_DEPTH = 64;
    localparam int ADDR_W = $clog2(DATA_DEPTH);
    localparam int CNT_W = $clog2(DATA_DEPTH + 1);
    localparam int INDEX_W = 6;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = CFG_IDX_W'(1);

    localparam logic [7:0] SYNC_FIRST_RESET = 8'h7E;
    localparam logic [7:0] SYNC_SECOND_RESET = 8'h23;
    localparam logic [7:0] MIN_LENGTH = 8'd5;
    localparam logic [7:0] HEADER_BYTES = 8'd4;

    typedef struct packed {
        logic [7:0]        func;
        logic [ADDR_W-1:0] plen;
        logic              err;
        logic [31:0]       good;
        logic [31:0]       bad;
    } t_job;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_mem_wr;

    typedef struct packed {
        logic busy;
    } t_back_status;

    typedef struct packed {
        logic [7:0]         func_code;
        logic [7:0]         payload_byte;
        logic [INDEX_W-1:0] byte_index;
        logic               byte_valid;
        logic               checksum_error;
        logic               last;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
    } t_result;

endpackage

/* src/slfd_front.sv */
module slfd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [7:0]                    i_rx_byte,
    output logic                          o_full,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [slfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                    i_cfg_data,
    input  logic                          i_q_empty,
    input  logic                          i_q_full,
    input  slfd_pkg::t_back_status        i_back,
    output logic                          o_q_push,
    output slfd_pkg::t_job                o_q_job,
    output slfd_pkg::t_mem_wr             o_mem_wr
);

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LENGTH,
        PH_FUNCTION,
        PH_DATA
    } t_phase;

    localparam logic [8:0] DEPTH9 = 9'(slfd_pkg::DATA_DEPTH);

    t_phase                     r_phase, n_phase;
    logic [7:0]                 r_length, n_length;
    logic [7:0]                 r_function, n_function;
    logic [slfd_pkg::CNT_W-1:0] r_count, n_count;
    logic [7:0]                 r_sum, n_sum;
    logic [31:0]                r_good, n_good;
    logic [31:0]                r_bad, n_bad;
    logic [7:0]                 r_sync_first;
    logic [7:0]                 r_sync_second;

    logic       accept;
    logic [7:0] dlen;
    logic       len_bad;
    logic       more_data;
    logic [7:0] check;
    logic       sum_ok;

    assign o_cfg_ready = 1'b1;
    assign o_full = (r_phase == PH_DATA) && (!i_q_empty || i_back.busy || i_q_full);
    assign accept = i_push && !o_full;

    assign dlen = (r_length >= slfd_pkg::MIN_LENGTH) ? r_length - slfd_pkg::HEADER_BYTES : 8'd0;
    assign len_bad = (dlen == 8'd0) || ({1'b0, dlen} > DEPTH9)
                     || (9'(r_count) >= {1'b0, dlen});
    assign more_data = (9'(r_count) + 9'd1) < {1'b0, dlen};
    assign check = r_sync_first + r_sync_second + r_length + r_function + r_sum;
    assign sum_ok = (check == i_rx_byte);

    always_comb begin
        n_phase = r_phase;
        n_length = r_length;
        n_function = r_function;
        n_count = r_count;
        n_sum = r_sum;
        n_good = r_good;
        n_bad = r_bad;
        o_q_push = 1'b0;
        o_mem_wr.we = 1'b0;
        o_mem_wr.addr = r_count[slfd_pkg::ADDR_W-1:0];
        o_mem_wr.data = i_rx_byte;
        o_q_job.func = r_function;
        o_q_job.plen = slfd_pkg::ADDR_W'(dlen - 8'd1);
        o_q_job.err = !sum_ok;
        o_q_job.good = r_good + 32'(sum_ok);
        o_q_job.bad = r_bad + 32'(!sum_ok);
        if (accept) begin
            case (r_phase)
                PH_SYNC1: begin
                    n_phase = (i_rx_byte == r_sync_first) ? PH_SYNC2 : PH_SYNC1;
                end
                PH_SYNC2: begin
                    n_phase = (i_rx_byte == r_sync_second) ? PH_LENGTH : PH_SYNC1;
                end
                PH_LENGTH: begin
                    n_length = i_rx_byte;
                    n_phase = PH_FUNCTION;
                end
                PH_FUNCTION: begin
                    n_function = i_rx_byte;
                    n_count = '0;
                    n_sum = '0;
                    n_phase = PH_DATA;
                end
                PH_DATA: begin
                    if (len_bad) begin
                        n_phase = PH_SYNC1;
                    end else if (more_data) begin
                        o_mem_wr.we = 1'b1;
                        n_sum = r_sum + i_rx_byte;
                        n_count = r_count + slfd_pkg::CNT_W'(1);
                    end else begin
                        o_q_push = 1'b1;
                        n_good = o_q_job.good;
                        n_bad = o_q_job.bad;
                        n_count = '0;
                        n_phase = PH_SYNC1;
                    end
                end
                default: begin
                    n_phase = PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC1;
            r_length <= '0;
            r_function <= '0;
            r_count <= '0;
            r_sum <= '0;
            r_good <= '0;
            r_bad <= '0;
            r_sync_first <= slfd_pkg::SYNC_FIRST_RESET;
            r_sync_second <= slfd_pkg::SYNC_SECOND_RESET;
        end else begin
            r_phase <= n_phase;
            r_length <= n_length;
            r_function <= n_function;
            r_count <= n_count;
            r_sum <= n_sum;
            r_good <= n_good;
            r_bad <= n_bad;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == slfd_pkg::REG_SYNC_FIRST) begin
                    r_sync_first <= i_cfg_data;
                end else if (i_cfg_index == slfd_pkg::REG_SYNC_SECOND) begin
                    r_sync_second <= i_cfg_data;
                end
            end
        end
    end

    a_no_write_during_replay: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_wr.we |-> (!i_back.busy && i_q_empty))
        else $error("payload write while replay pending");

    a_push_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_push |=> (r_phase == PH_SYNC1) && (r_count == '0))
        else $error("frame end did not restart hunting");

endmodule

/* src/slfd_queue.sv */
module slfd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  slfd_pkg::t_job i_job,
    output logic           o_empty,
    output logic           o_full,
    input  logic           i_pop,
    output slfd_pkg::t_job o_job
);

    slfd_pkg::t_job                r_slot [slfd_pkg::QUEUE_DEPTH];
    logic [slfd_pkg::QPTR_W-1:0]   r_wr_ptr;
    logic [slfd_pkg::QPTR_W-1:0]   r_rd_ptr;
    logic [slfd_pkg::QCNT_W-1:0]   r_count;
    logic                          do_push;
    logic                          do_pop;

    assign o_empty = (r_count == '0);
    assign o_full = (r_count == slfd_pkg::QCNT_W'(slfd_pkg::QUEUE_DEPTH));
    assign o_job = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + slfd_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + slfd_pkg::QPTR_W'(1);
            end
            r_count <= r_count + slfd_pkg::QCNT_W'(do_push) - slfd_pkg::QCNT_W'(do_pop);
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("job pushed into full queue");

endmodule

/* src/slfd_back.sv */
module slfd_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  slfd_pkg::t_mem_wr         i_mem_wr,
    input  logic                      i_q_empty,
    input  slfd_pkg::t_job            i_job,
    output logic                      o_q_pop,
    output slfd_pkg::t_back_status    o_status,
    output logic                      o_empty,
    input  logic                      i_pop,
    output slfd_pkg::t_result         o_result
);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_EMIT
    } t_state;

    localparam int IDX1_W = slfd_pkg::ADDR_W + 1;

    logic [7:0]                  r_mem [slfd_pkg::DATA_DEPTH];
    logic [7:0]                  r_rd_data;
    t_state                      r_state;
    logic [slfd_pkg::ADDR_W-1:0] r_idx;
    logic                        r_out_empty;
    slfd_pkg::t_result           r_out;

    logic              load;
    logic              no_data;
    logic              is_last;
    slfd_pkg::t_result n_out;

    assign o_empty = r_out_empty;
    assign o_result = r_out;
    assign o_status.busy = (r_state != BK_IDLE);

    assign no_data = i_job.err || (i_job.plen == '0);
    assign is_last = no_data || ((IDX1_W'(r_idx) + IDX1_W'(1)) == IDX1_W'(i_job.plen));
    assign load = (r_state == BK_EMIT) && (r_out_empty || i_pop);
    assign o_q_pop = load && is_last;

    always_comb begin
        n_out.func_code = i_job.func;
        n_out.payload_byte = no_data ? 8'd0 : r_rd_data;
        n_out.byte_index = no_data ? '0 : slfd_pkg::INDEX_W'(r_idx);
        n_out.byte_valid = !no_data;
        n_out.checksum_error = i_job.err;
        n_out.last = is_last;
        n_out.good_frames = i_job.good;
        n_out.bad_frames = i_job.bad;
    end

    always_ff @(posedge i_clk) begin
        if (i_mem_wr.we) begin
            r_mem[i_mem_wr.addr] <= i_mem_wr.data;
        end
        r_rd_data <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_idx <= '0;
            r_out_empty <= 1'b1;
        end else begin
            if (load) begin
                r_out <= n_out;
                r_out_empty <= 1'b0;
            end else if (i_pop && !r_out_empty) begin
                r_out_empty <= 1'b1;
            end
            case (r_state)
                BK_IDLE: begin
                    r_idx <= '0;
                    if (!i_q_empty) begin
                        r_state <= no_data ? BK_EMIT : BK_FETCH;
                    end
                end
                BK_FETCH: begin
                    r_state <= BK_EMIT;
                end
                BK_EMIT: begin
                    if (load) begin
                        if (is_last) begin
                            r_state <= BK_IDLE;
                        end else begin
                            r_idx <= r_idx + slfd_pkg::ADDR_W'(1);
                            r_state <= BK_FETCH;
                        end
                    end
                end
                default: begin
                    r_state <= BK_IDLE;
                end
            endcase
        end
    end

    a_result_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_empty) |-> $past(load))
        else $error("result appeared without a load");

    a_job_present_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> !i_q_empty)
        else $error("replay running without a job");

endmodule

/* src/sync_length_frame_deframer.sv */
// Input bytes are accepted one per cycle while full is low; full rises only
// in the data phase while the previous frame's results are still being replayed.
// Results follow the checksum byte; each payload byte goes through a payload
// memory read, then the output register, before the next byte is fetched.
// Reset is synchronous: control, counters and sync registers clear, memory does not.
module sync_length_frame_deframer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    input  logic [7:0]                     i_rx_byte,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    output logic [7:0]                     o_func_code,
    output logic [7:0]                     o_payload_byte,
    output logic [5:0]                     o_byte_index,
    output logic                           o_byte_valid,
    output logic                           o_checksum_error,
    output logic                           o_last,
    output logic [31:0]                    o_good_frames,
    output logic [31:0]                    o_bad_frames,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [slfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data
);

    logic                      q_push;
    logic                      q_pop;
    logic                      q_empty;
    logic                      q_full;
    slfd_pkg::t_job            front_job;
    slfd_pkg::t_job            head_job;
    slfd_pkg::t_mem_wr         mem_wr;
    slfd_pkg::t_back_status    back_status;
    slfd_pkg::t_result         result;

    slfd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_empty   (q_empty),
        .i_q_full    (q_full),
        .i_back      (back_status),
        .o_q_push    (q_push),
        .o_q_job     (front_job),
        .o_mem_wr    (mem_wr)
    );

    slfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_empty (q_empty),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job)
    );

    slfd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mem_wr  (mem_wr),
        .i_q_empty (q_empty),
        .i_job     (head_job),
        .o_q_pop   (q_pop),
        .o_status  (back_status),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (result)
    );

    assign o_func_code = result.func_code;
    assign o_payload_byte = result.payload_byte;
    assign o_byte_index = result.byte_index;
    assign o_byte_valid = result.byte_valid;
    assign o_checksum_error = result.checksum_error;
    assign o_last = result.last;
    assign o_good_frames = result.good_frames;
    assign o_bad_frames = result.bad_frames;

endmodule

/* sim/sync_length_frame_deframer_checker.sv */
`timescale 1ns / 1ps
module sync_length_frame_deframer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    input  logic                           i_full,
    input  logic [7:0]                     i_rx_byte,
    input  logic                           i_pop,
    input  logic                           i_empty,
    input  slfd_pkg::t_result              i_result,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [slfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        TAKE_FUNCTION,
        TAKE_DATA
    } t_parse_phase;

    t_parse_phase      phase;
    logic [7:0]        sync_a;
    logic [7:0]        sync_b;
    logic [7:0]        len_q;
    logic [7:0]        func_q;
    logic [7:0]        sum_q;
    int                count_q;
    logic [7:0]        store [slfd_pkg::DATA_DEPTH];
    logic [31:0]       good_q;
    logic [31:0]       bad_q;
    slfd_pkg::t_result frame_results_q[$];
    int                fails = 0;

    task automatic reset_model();
        phase = HUNT_FIRST;
        sync_a = slfd_pkg::SYNC_FIRST_RESET;
        sync_b = slfd_pkg::SYNC_SECOND_RESET;
        len_q = '0;
        func_q = '0;
        sum_q = '0;
        count_q = 0;
        good_q = '0;
        bad_q = '0;
        frame_results_q.delete();
    endtask

    function automatic slfd_pkg::t_result make_result(logic [7:0] pb, int idx, logic valid,
                                                      logic err, logic lst);
        slfd_pkg::t_result r;
        r.func_code = func_q;
        r.payload_byte = pb;
        r.byte_index = slfd_pkg::INDEX_W'(idx);
        r.byte_valid = valid;
        r.checksum_error = err;
        r.last = lst;
        r.good_frames = good_q;
        r.bad_frames = bad_q;
        return r;
    endfunction

    task automatic parse_byte(input logic [7:0] rx);
        int         dlen;
        int         plen;
        logic [7:0] sum;
        case (phase)
            HUNT_FIRST: phase = (rx == sync_a) ? HUNT_SECOND : HUNT_FIRST;
            HUNT_SECOND: phase = (rx == sync_b) ? TAKE_LENGTH : HUNT_FIRST;
            TAKE_LENGTH: begin
                len_q = rx;
                phase = TAKE_FUNCTION;
            end
            TAKE_FUNCTION: begin
                func_q = rx;
                count_q = 0;
                sum_q = '0;
                phase = TAKE_DATA;
            end
            TAKE_DATA: begin
                dlen = (len_q >= slfd_pkg::MIN_LENGTH)
                       ? int'(len_q) - int'(slfd_pkg::HEADER_BYTES) : 0;
                if (dlen == 0 || dlen > slfd_pkg::DATA_DEPTH || count_q >= dlen) begin
                    phase = HUNT_FIRST;
                end else if (count_q + 1 < dlen) begin
                    store[count_q] = rx;
                    sum_q = sum_q + rx;
                    count_q++;
                end else begin
                    sum = sync_a + sync_b + len_q + func_q + sum_q;
                    plen = dlen - 1;
                    if (sum == rx) begin
                        good_q++;
                        if (plen == 0) begin
                            frame_results_q.push_back(make_result(8'h00, 0, 1'b0, 1'b0, 1'b1));
                        end else begin
                            for (int i = 0; i < plen; i++) begin
                                frame_results_q.push_back(make_result(store[i], i, 1'b1, 1'b0,
                                                                      i + 1 == plen));
                            end
                        end
                    end else begin
                        bad_q++;
                        frame_results_q.push_back(make_result(8'h00, 0, 1'b0, 1'b1, 1'b1));
                    end
                    count_q = 0;
                    phase = HUNT_FIRST;
                end
            end
            default: phase = HUNT_FIRST;
        endcase
    endtask

    task automatic check_result(input slfd_pkg::t_result got);
        slfd_pkg::t_result want;
        bit                bad;
        if (frame_results_q.size() == 0) begin
            fails++;
            if (fails <= 10) begin
                $display("%0t: result with none pending: func=%h byte=%h idx=%0d",
                         $realtime, got.func_code, got.payload_byte, got.byte_index);
            end
        end else begin
            want = frame_results_q.pop_front();
            bad = (got.func_code !== want.func_code)
                || (got.payload_byte !== want.payload_byte)
                || (got.byte_index !== want.byte_index)
                || (got.byte_valid !== want.byte_valid)
                || (got.checksum_error !== want.checksum_error)
                || (got.last !== want.last)
                || (got.good_frames !== want.good_frames)
                || (got.bad_frames !== want.bad_frames);
            if (bad) begin
                fails++;
                if (fails <= 10) begin
                    $display({"%0t: mismatch exp func=%h byte=%h idx=%0d v=%b err=%b",
                              " last=%b g=%0d b=%0d"},
                             $realtime, want.func_code, want.payload_byte,
                             want.byte_index, want.byte_valid, want.checksum_error,
                             want.last, want.good_frames, want.bad_frames);
                    $display({"            got func=%h byte=%h idx=%0d v=%b err=%b",
                              " last=%b g=%0d b=%0d"},
                             got.func_code, got.payload_byte, got.byte_index,
                             got.byte_valid, got.checksum_error, got.last,
                             got.good_frames, got.bad_frames);
                end
            end
        end
    endtask

    initial reset_model();

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    slfd_pkg::REG_SYNC_FIRST: sync_a = i_cfg_data;
                    slfd_pkg::REG_SYNC_SECOND: sync_b = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                parse_byte(i_rx_byte);
            end
            if (i_pop && !i_empty) begin
                check_result(i_result);
            end
        end
        o_fail_count <= fails;
        o_pending <= frame_results_q.size();
    end

endmodule

/* sim/sync_length_frame_deframer_tb.sv */
`timescale 1ns / 1ps
module sync_length_frame_deframer_tb;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           pop = 1'b0;
    logic [7:0]                     i_rx_byte = 8'h00;
    logic                           i_cfg_valid = 1'b0;
    logic [slfd_pkg::CFG_IDX_W-1:0] i_cfg_index = slfd_pkg::REG_SYNC_FIRST;
    logic [7:0]                     i_cfg_data = 8'h00;

    logic        full;
    logic        empty;
    logic [7:0]  o_func_code;
    logic [7:0]  o_payload_byte;
    logic [5:0]  o_byte_index;
    logic        o_byte_valid;
    logic        o_checksum_error;
    logic        o_last;
    logic [31:0] o_good_frames;
    logic [31:0] o_bad_frames;
    logic        o_cfg_ready;

    slfd_pkg::t_result seen;
    int                fail_count;
    int                pending;

    logic [7:0] cur_first = slfd_pkg::SYNC_FIRST_RESET;
    logic [7:0] cur_second = slfd_pkg::SYNC_SECOND_RESET;
    logic [7:0] pay_q[$];
    int         n_sent = 0;
    int         gap_rate = 0;
    bit         quiet = 1'b0;

    assign seen = {o_func_code, o_payload_byte, o_byte_index, o_byte_valid,
                   o_checksum_error, o_last, o_good_frames, o_bad_frames};

    always #4 i_clk = ~i_clk;

    sync_length_frame_deframer dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .i_rx_byte        (i_rx_byte),
        .full             (full),
        .empty            (empty),
        .pop              (pop),
        .o_func_code      (o_func_code),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_byte_valid     (o_byte_valid),
        .o_checksum_error (o_checksum_error),
        .o_last           (o_last),
        .o_good_frames    (o_good_frames),
        .o_bad_frames     (o_bad_frames),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    sync_length_frame_deframer_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_rx_byte    (i_rx_byte),
        .i_pop        (pop),
        .i_empty      (empty),
        .i_result     (seen),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge i_clk);
        end else begin
            pop <= 1'b1;
            repeat ($urandom_range(0, 15)) @(negedge i_clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gap_rate > 0 && $urandom_range(1, gap_rate) == 1) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        push <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (full);
        @(negedge i_clk);
        n_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] func, input bit corrupt);
        logic [7:0] sum;
        sum = cur_first + cur_second + len + func;
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(len);
        send_byte(func);
        foreach (pay_q[k]) begin
            send_byte(pay_q[k]);
            sum = sum + pay_q[k];
        end
        if (corrupt) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        send_byte(sum);
    endtask

    task automatic fill_payload(input int n);
        pay_q.delete();
        repeat (n) pay_q.push_back(8'($urandom_range(0, 255)));
    endtask

    // hold off the sender until every request has produced its results
    task automatic wait_drained();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= slfd_pkg::REG_SYNC_FIRST;
        i_cfg_data <= first;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_index <= slfd_pkg::REG_SYNC_SECOND;
        i_cfg_data <= second;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_first = first;
        cur_second = second;
        @(negedge i_clk);
    endtask

    task automatic send_random(input int until_count);
        int         kind;
        int         len;
        logic [7:0] x;
        while (n_sent < until_count) begin
            kind = $urandom_range(0, 99);
            if (kind < 85) begin
                len = ($urandom_range(0, 19) == 0) ? slfd_pkg::DATA_DEPTH + 4
                                                   : $urandom_range(5, 12);
                fill_payload(len - 5);
                send_frame(8'(len), 8'($urandom_range(0, 255)), kind >= 70);
            end else if (kind < 90) begin
                len = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4)
                                                  : $urandom_range(slfd_pkg::DATA_DEPTH + 5, 255);
                send_byte(cur_first);
                send_byte(cur_second);
                send_byte(8'(len));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(8'($urandom_range(0, 255)));
            end else if (kind < 95) begin
                x = 8'($urandom_range(0, 255));
                if (x == cur_second) x = x ^ 8'h01;
                send_byte(cur_first);
                send_byte(x);
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    x = 8'($urandom_range(0, 255));
                    if (x == cur_first) x = x ^ 8'h01;
                    send_byte(x);
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        gap_rate = 4;
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(8'd0);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(cur_first);
        send_byte(cur_first);
        pay_q.delete();
        send_frame(slfd_pkg::MIN_LENGTH, 8'h00, 1'b0);
        send_frame(slfd_pkg::MIN_LENGTH, 8'h12, 1'b1);
        pay_q = '{8'h00, 8'hFF};
        send_frame(8'd7, 8'hFF, 1'b0);

        send_random(110);

        // change the sync registers with a frame half received
        send_byte(cur_first);
        send_byte(cur_second);
        send_byte(8'd7);
        send_byte(8'h3C);
        send_byte(8'hA5);
        wait_drained();
        set_sync(8'h00, 8'hFF);
        send_byte(8'h5A);
        send_byte(cur_first + cur_second + 8'd7 + 8'h3C + 8'hA5 + 8'h5A);

        gap_rate = 0;
        send_random(200);

        wait_drained();
        set_sync(8'hFF, 8'h00);
        gap_rate = 3;
        send_random(280);

        wait_drained();
        set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        gap_rate = 0;
        quiet = 1'b1;
        send_random(364);

        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** sync_length_frame_deframer: PASSED **");
        end else begin
            $display("** sync_length_frame_deframer: FAILED **");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("** sync_length_frame_deframer: FAILED **");
        $finish;
    end

endmodule

/* files.f */
src/slfd_pkg.sv
src/slfd_front.sv
src/slfd_queue.sv
src/slfd_back.sv
src/sync_length_frame_deframer.sv
sim/sync_length_frame_deframer_checker.sv
sim/sync_length_frame_deframer_tb.sv
